FILE: src/fmam_pkg.sv
// shared types, codes and constants of the fm/am iq demodulator
package fmam_pkg;

  // width of the step counter shared by the cordic and the square root
  localparam int STEP_W = 5;

  // modulation register
  localparam int MOD_W = 2;
  localparam logic [MOD_W-1:0] MODE_FM = 2'd0;
  localparam logic [MOD_W-1:0] MODE_AM = 2'd1;

  // angle format: pi is 2^24
  localparam int ANGLE_FRAC = 24;
  localparam int ANG_W      = 23;
  localparam int ANGLE_LEN  = 24;
  localparam int ZW         = 27;
  localparam logic signed [ZW-1:0] HALF_PI = 27'sd8388608;

  // multiply-accumulate operations
  localparam int MAC_OP_W = 3;
  localparam logic [MAC_OP_W-1:0] MAC_RE_SET_IPI = 3'd0;
  localparam logic [MAC_OP_W-1:0] MAC_RE_ADD_QPQ = 3'd1;
  localparam logic [MAC_OP_W-1:0] MAC_IM_SET_QPI = 3'd2;
  localparam logic [MAC_OP_W-1:0] MAC_IM_SUB_IPQ = 3'd3;
  localparam logic [MAC_OP_W-1:0] MAC_RE_SET_II  = 3'd4;
  localparam logic [MAC_OP_W-1:0] MAC_RE_ADD_QQ  = 3'd5;

  // result select
  localparam int OUT_SEL_W = 2;
  localparam logic [OUT_SEL_W-1:0] OUT_SEL_ZERO = 2'd0;
  localparam logic [OUT_SEL_W-1:0] OUT_SEL_FM   = 2'd1;
  localparam logic [OUT_SEL_W-1:0] OUT_SEL_AM   = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                 load;
    logic                 mac_en;
    logic [MAC_OP_W-1:0]  mac_op;
    logic                 cordic_init;
    logic                 cordic_step;
    logic                 sqrt_init;
    logic                 sqrt_step;
    logic [STEP_W-1:0]    step;
    logic                 out_load;
    logic [OUT_SEL_W-1:0] out_sel;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic prod_zero;
  } status_t;

  // atan(2^-i) in units where pi is 2^24, rounded
  function automatic logic [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 23'd4194304;
      5'd1:  v = 23'd2476042;
      5'd2:  v = 23'd1308273;
      5'd3:  v = 23'd664100;
      5'd4:  v = 23'd333339;
      5'd5:  v = 23'd166832;
      5'd6:  v = 23'd83436;
      5'd7:  v = 23'd41721;
      5'd8:  v = 23'd20861;
      5'd9:  v = 23'd10430;
      5'd10: v = 23'd5215;
      5'd11: v = 23'd2608;
      5'd12: v = 23'd1304;
      5'd13: v = 23'd652;
      5'd14: v = 23'd326;
      5'd15: v = 23'd163;
      5'd16: v = 23'd81;
      5'd17: v = 23'd41;
      5'd18: v = 23'd20;
      5'd19: v = 23'd10;
      5'd20: v = 23'd5;
      5'd21: v = 23'd3;
      5'd22: v = 23'd1;
      5'd23: v = 23'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/fm_am_iq_demodulator.sv
// top level of the fm/am iq demodulator
//
// Input stream (s_*): one complex baseband sample per transaction, I and Q
// signed with SAMPLE_WIDTH-1 fraction bits. Output stream (m_*): one
// demodulated value per input, same format. cfg_we/cfg_wdata write the
// 2-bit modulation register (0 fm discriminator, 1 am envelope, 2-3 zero);
// write it only while no transaction is in flight.
// Each item runs in order: fm does the multiply-accumulate steps, a setup
// step, the cordic rotations and a finish step that loads the result; a
// zero product skips the rotations. am does the multiply steps, a setup
// step, the square-root bits and the finish step. The other modes go
// straight to the finish step. The next sample is accepted in the cycle
// after the result is loaded, when the sequencer is back in idle.
// The rate is set by the single shared multiplier and by the iterative cordic
// and square-root units, one step per cycle. One item is processed at a time;
// s_tready is high while the sequencer is idle, even if a result still waits
// in the output register. If m_tready stays low the finished next result is
// held until the output register is free. Reset clears the stored fm sample
// to zero, selects fm mode and empties the output register.
module fm_am_iq_demodulator #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [fmam_pkg::MOD_W-1:0]               cfg_wdata,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // in_phase, quadrature, zero fill
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // demod_value, zero fill
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_tdata
);
  import fmam_pkg::*;

  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

  cmd_t                           cmd;
  status_t                        status;
  logic signed [SAMPLE_WIDTH-1:0] in_phase, quadrature, demod_value;

  // unpack the input transaction
  assign in_phase   = s_tdata[SAMPLE_WIDTH-1:0];
  assign quadrature = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  // pack the output transaction
  assign m_tdata = OUT_TDATA_W'($unsigned(demod_value));

  fmam_ctrl #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  fmam_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_phase    (in_phase),
    .quadrature  (quadrature),
    .demod_value (demod_value)
  );

endmodule

FILE: src/fmam_datapath.sv
// datapath: sample registers, shared multiplier, cordic, square root, output register
module fmam_datapath #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fmam_pkg::cmd_t                 cmd,
  output fmam_pkg::status_t              status,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phase,
  input  logic signed [SAMPLE_WIDTH-1:0] quadrature,
  output logic signed [SAMPLE_WIDTH-1:0] demod_value
);
  import fmam_pkg::*;

  localparam int PW        = 2 * SAMPLE_WIDTH;
  localparam int AW        = PW + 1;
  localparam int XW        = PW + 3;
  localparam int NR        = SAMPLE_WIDTH + 1;
  localparam int RADW      = 2 * NR;
  localparam int REMW      = NR + 1;
  localparam int OUT_SHIFT = ANGLE_FRAC + 1 - SAMPLE_WIDTH;
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(2 ** (OUT_SHIFT - 1));
  localparam logic signed [ZW-1:0] OUT_MAX    = ZW'(2 ** (SAMPLE_WIDTH - 1) - 1);
  localparam logic signed [ZW-1:0] OUT_MIN    = ZW'(-(2 ** (SAMPLE_WIDTH - 1)));
  localparam logic [NR-1:0]        AM_MAX     = NR'(2 ** (SAMPLE_WIDTH - 1) - 1);

  logic signed [SAMPLE_WIDTH-1:0] cur_i, cur_q, prev_i, prev_q, mul_a, mul_b;
  logic signed [PW-1:0]           prod;
  logic signed [AW-1:0]           prod_ext, acc_re, acc_im;
  logic signed [XW-1:0]           x, y, re_x, im_x, dx, dy;
  logic signed [ZW-1:0]           z, ang, z_round, z_shift;
  logic                           zero_prod;
  logic [RADW-1:0]                rad;
  logic [REMW-1:0]                rem;
  logic [NR-1:0]                  root, am_half;
  logic [REMW+1:0]                rem_sh, trial;
  logic                           sqrt_ge;
  logic [NR:0]                    root_inc;
  logic signed [SAMPLE_WIDTH-1:0] fm_val, am_val;

  // multiplier operand select
  always_comb begin
    case (cmd.mac_op)
      MAC_RE_SET_IPI: begin mul_a = cur_i; mul_b = prev_i; end
      MAC_RE_ADD_QPQ: begin mul_a = cur_q; mul_b = prev_q; end
      MAC_IM_SET_QPI: begin mul_a = cur_q; mul_b = prev_i; end
      MAC_IM_SUB_IPQ: begin mul_a = cur_i; mul_b = prev_q; end
      MAC_RE_SET_II:  begin mul_a = cur_i; mul_b = cur_i; end
      MAC_RE_ADD_QQ:  begin mul_a = cur_q; mul_b = cur_q; end
      default:        begin mul_a = '0;    mul_b = '0; end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = AW'(prod);

  // stored fm sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_i <= '0;
      prev_q <= '0;
    end else if (cmd.mac_en && cmd.mac_op == MAC_IM_SUB_IPQ) begin
      prev_i <= cur_i;
      prev_q <= cur_q;
    end
  end

  // current sample and product accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_i <= in_phase;
      cur_q <= quadrature;
    end
    if (cmd.mac_en) begin
      case (cmd.mac_op)
        MAC_RE_SET_IPI: acc_re <= prod_ext;
        MAC_RE_ADD_QPQ: acc_re <= acc_re + prod_ext;
        MAC_IM_SET_QPI: acc_im <= prod_ext;
        MAC_IM_SUB_IPQ: acc_im <= acc_im - prod_ext;
        MAC_RE_SET_II:  acc_re <= prod_ext;
        MAC_RE_ADD_QQ:  acc_re <= acc_re + prod_ext;
        default:        acc_re <= acc_re;
      endcase
    end
  end

  assign status.prod_zero = (acc_re == '0) && (acc_im == '0);

  // cordic micro-rotation terms
  assign re_x = XW'(acc_re);
  assign im_x = XW'(acc_im);
  assign dx   = y >>> cmd.step;
  assign dy   = x >>> cmd.step;
  assign ang  = {{(ZW - ANG_W){1'b0}}, atan_entry(cmd.step)};

  // cordic vectoring, one rotation per cycle
  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      zero_prod <= status.prod_zero;
      if (re_x < 0) begin
        if (im_x >= 0) begin
          x <= im_x;
          y <= -re_x;
          z <= HALF_PI;
        end else begin
          x <= -im_x;
          y <= re_x;
          z <= -HALF_PI;
        end
      end else begin
        x <= re_x;
        y <= im_x;
        z <= '0;
      end
    end else if (cmd.cordic_step) begin
      if (y >= 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + ang;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - ang;
      end
    end
  end

  // restoring square root, one result bit per cycle
  assign rem_sh  = {rem, rad[RADW-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign sqrt_ge = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad  <= {1'b0, acc_re[PW-1:0], 1'b0};
      rem  <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      rad  <= rad << 2;
      rem  <= sqrt_ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
      root <= {root[NR-2:0], sqrt_ge};
    end
  end

  // fm result: round the angle to the output scale and clamp
  assign z_round = z + ROUND_HALF;
  assign z_shift = z_round >>> OUT_SHIFT;

  always_comb begin
    if (z_shift > OUT_MAX) begin
      fm_val = SAMPLE_WIDTH'(OUT_MAX);
    end else if (z_shift < OUT_MIN) begin
      fm_val = SAMPLE_WIDTH'(OUT_MIN);
    end else begin
      fm_val = SAMPLE_WIDTH'(z_shift);
    end
  end

  // am result: halve the root of twice the power with rounding, clamp
  assign root_inc = {1'b0, root} + (NR+1)'(1);
  assign am_half  = root_inc[NR:1];
  assign am_val   = (am_half > AM_MAX) ? SAMPLE_WIDTH'(AM_MAX) : SAMPLE_WIDTH'(am_half);

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_SEL_FM: demod_value <= zero_prod ? '0 : fm_val;
        OUT_SEL_AM: demod_value <= am_val;
        default:    demod_value <= '0;
      endcase
    end
  end

endmodule

FILE: src/fmam_ctrl.sv
// controller: handshakes, modulation register and sequencing of the datapath
module fmam_ctrl #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [fmam_pkg::MOD_W-1:0]   cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output fmam_pkg::cmd_t               cmd,
  input  fmam_pkg::status_t            status
);
  import fmam_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_CORDIC = 3'd3;
  localparam logic [2:0] ST_SQRT   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam logic [STEP_W-1:0] LAST_CORDIC = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [STEP_W-1:0] LAST_SQRT   = STEP_W'(SAMPLE_WIDTH);
  localparam logic [STEP_W-1:0] LAST_MAC_FM = STEP_W'(3);
  localparam logic [STEP_W-1:0] LAST_MAC_AM = STEP_W'(1);

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic [MOD_W-1:0]  modulation, item_mode, item_mode_next;
  logic              out_valid, out_valid_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // sequencing
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    item_mode_next = item_mode;
    cmd            = '0;
    cmd.step       = cnt;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load       = 1'b1;
          item_mode_next = modulation;
          cnt_next       = '0;
          if (modulation == MODE_FM || modulation == MODE_AM) begin
            state_next = ST_MAC;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_en = 1'b1;
        if (item_mode == MODE_FM) begin
          case (cnt[1:0])
            2'd0:    cmd.mac_op = MAC_RE_SET_IPI;
            2'd1:    cmd.mac_op = MAC_RE_ADD_QPQ;
            2'd2:    cmd.mac_op = MAC_IM_SET_QPI;
            default: cmd.mac_op = MAC_IM_SUB_IPQ;
          endcase
        end else begin
          cmd.mac_op = cnt[0] ? MAC_RE_ADD_QQ : MAC_RE_SET_II;
        end
        if ((item_mode == MODE_FM && cnt == LAST_MAC_FM) ||
            (item_mode != MODE_FM && cnt == LAST_MAC_AM)) begin
          cnt_next   = '0;
          state_next = ST_PREP;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_PREP: begin
        cnt_next = '0;
        if (item_mode == MODE_FM) begin
          cmd.cordic_init = 1'b1;
          state_next = status.prod_zero ? ST_FINISH : ST_CORDIC;
        end else begin
          cmd.sqrt_init = 1'b1;
          state_next    = ST_SQRT;
        end
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (cnt == LAST_CORDIC) begin
          cnt_next   = '0;
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == LAST_SQRT) begin
          cnt_next   = '0;
          state_next = ST_FINISH;
        end else begin
          cnt_next = cnt + STEP_W'(1);
        end
      end
      ST_FINISH: begin
        case (item_mode)
          MODE_FM: cmd.out_sel = OUT_SEL_FM;
          MODE_AM: cmd.out_sel = OUT_SEL_AM;
          default: cmd.out_sel = OUT_SEL_ZERO;
        endcase
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output transaction pending flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      item_mode  <= MODE_FM;
      modulation <= MODE_FM;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      item_mode <= item_mode_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        modulation <= cfg_wdata;
      end
    end
  end

`ifndef SYNTHESIS
  // a held result is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("output register overwritten while a result waits");

  // unused modes go straight to the result
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && s_tvalid && modulation != MODE_FM && modulation != MODE_AM)
    |=> state == ST_FINISH)
    else $error("unused mode did not skip to the result");

  // the cordic runs only for fm items
  assert property (@(posedge clk) disable iff (rst)
    state == ST_CORDIC |-> item_mode == MODE_FM)
    else $error("cordic active outside fm mode");

  // am takes only two multiply steps
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC && item_mode == MODE_AM) |-> cnt < STEP_W'(2))
    else $error("am multiply sequence overran");

  // a result appears only from the finish state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result valid raised outside finish");
`endif

endmodule

FILE: dv/tb_fm_am_iq_demodulator.sv
// self-checking testbench for the fm/am iq demodulator with a bit-exact predictor
module tb_fm_am_iq_demodulator;
  timeunit 1ns;
  timeprecision 1ps;

  import fmam_pkg::*;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int CORDIC_STEPS   = 16;
  localparam int TIMEOUT_CYCLES = 2000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int LONG_HOLD      = 300;
  localparam logic [MOD_W-1:0] MODE_OFF_2 = 2'd2;
  localparam logic [MOD_W-1:0] MODE_OFF_3 = 2'd3;
  localparam logic signed [15:0] CODE_MAX = 16'sh7fff;
  localparam logic signed [15:0] CODE_MIN = 16'sh8000;
  localparam real PI_R = 3.14159265358979;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [MOD_W-1:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // in_phase, quadrature
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // demod_value
  logic [15:0] m_tdata;

  // predictor state
  logic [MOD_W-1:0]   active_mode = MODE_FM;
  logic signed [15:0] fm_prev_i = '0;
  logic signed [15:0] fm_prev_q = '0;
  logic [15:0]        expected_demod [$];

  int error_count       = 0;
  int sink_hold_request = 0;
  int sender_burst      = 0;
  int stall_cycles      = 0;
  bit offering          = 1'b0;

  fm_am_iq_demodulator #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // micro-rotation angles, pi = 2^24
  function automatic longint arctan_step(input int k);
    case (k)
      0:  return 4194304;
      1:  return 2476042;
      2:  return 1308273;
      3:  return 664100;
      4:  return 333339;
      5:  return 166832;
      6:  return 83436;
      7:  return 41721;
      8:  return 20861;
      9:  return 10430;
      10: return 5215;
      11: return 2608;
      12: return 1304;
      13: return 652;
      14: return 326;
      15: return 163;
      16: return 81;
      17: return 41;
      18: return 20;
      19: return 10;
      20: return 5;
      21: return 3;
      default: return 1;
    endcase
  endfunction

  // phase of (re, im) divided by pi, as a saturated q1.15 code
  function automatic logic [15:0] fm_angle(input longint re, input longint im);
    longint x, y, z, t, dx, dy;
    int k;
    x = re;
    y = im;
    z = 0;
    // pre-rotate the left half plane by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 64'sd8388608;
      end else begin
        x = -y;
        y = t;
        z = -64'sd8388608;
      end
    end
    for (k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_step(k);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_step(k);
      end
    end
    z = (z + (64'sd1 <<< (24 - SAMPLE_WIDTH))) >>> (25 - SAMPLE_WIDTH);
    if (z > 32767) z = 32767;
    if (z < -32768) z = -32768;
    return z[15:0];
  endfunction

  // floor of the square root, one result bit at a time
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, cand;
    int b;
    r = 0;
    for (b = 17; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // expected demod_value for one sample; in fm mode it advances the stored fm sample
  function automatic logic [15:0] demodulate_expected(input logic signed [15:0] i_s,
                                                      input logic signed [15:0] q_s);
    longint il, ql, pil, pql, re, im;
    longint unsigned power;
    logic [15:0] v;
    il = i_s;
    ql = q_s;
    v  = '0;
    if (active_mode == MODE_FM) begin
      pil = fm_prev_i;
      pql = fm_prev_q;
      re  = il * pil + ql * pql;
      im  = ql * pil - il * pql;
      if (re != 0 || im != 0) v = fm_angle(re, im);
      fm_prev_i = i_s;
      fm_prev_q = q_s;
    end else if (active_mode == MODE_AM) begin
      power = il * il + ql * ql;
      power = (root_floor(power << 1) + 1) >> 1;
      if (power > 32767) power = 32767;
      v = power[15:0];
    end
    return v;
  endfunction

  // idle cycles after a sample: mostly none or short, a few long, some bursts
  function automatic int pick_gap();
    int r;
    if (sender_burst > 0) begin
      sender_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      sender_burst = $urandom_range(40, 120);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one input transaction, then an optional idle gap
  task automatic send_sample(input logic signed [15:0] i_s, input logic signed [15:0] q_s,
                             input bit no_gap);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {q_s, i_s};
    offering = 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_demod.push_back(demodulate_expected(i_s, q_s));
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every pending result come out
  task automatic wait_for_results();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_demod.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic set_mode(input logic [MOD_W-1:0] m);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_mode = m;
  endtask

  // random field value with extra weight on extremes and small magnitudes
  function automatic logic signed [15:0] random_component();
    int r;
    logic [31:0] u;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return CODE_MIN;
        1: return CODE_MAX;
        2: return 16'sd0;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    if (r < 3) begin
      u = $urandom_range(0, 512) - 256;
      return u[15:0];
    end
    u = $urandom();
    return u[15:0];
  endfunction

  function automatic logic signed [15:0] to_code(input real v);
    if (v >= 32767.0) return CODE_MAX;
    if (v <= -32768.0) return CODE_MIN;
    return 16'($rtoi(v));
  endfunction

  // reset state: fm mode with a zero stored sample, so the first product is zero
  task automatic test_reset_state();
    send_sample(16'sd12000, -16'sd7000, 1'b0);
    send_sample(CODE_MIN, CODE_MAX, 1'b0);
  endtask

  // fm extremes, phase of pi, zero products and both left half plane branches
  task automatic test_fm_directed();
    set_mode(MODE_FM);
    send_sample(CODE_MAX, CODE_MAX, 1'b0);
    send_sample(CODE_MIN, CODE_MIN, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd16384, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sd16384, 1'b0);
    send_sample(16'sd16384, 16'sd0, 1'b0);
    send_sample(-16'sd16384, -16'sd1, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b0);
  endtask

  // am extremes including full-scale saturation
  task automatic test_am_directed();
    set_mode(MODE_AM);
    send_sample(CODE_MIN, CODE_MIN, 1'b0);
    send_sample(CODE_MAX, CODE_MAX, 1'b0);
    send_sample(CODE_MIN, 16'sd0, 1'b0);
    send_sample(16'sd0, CODE_MAX, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b0);
    send_sample(-16'sd1, 16'sd0, 1'b0);
    send_sample(16'sd23170, -16'sd23170, 1'b0);
  endtask

  // unused modes give zero; fm then resumes from the last fm sample
  task automatic test_unused_modes();
    set_mode(MODE_OFF_2);
    send_sample(CODE_MIN, CODE_MAX, 1'b0);
    send_sample(CODE_MAX, CODE_MIN, 1'b0);
    set_mode(MODE_OFF_3);
    send_sample(16'sd1, 16'sd1, 1'b0);
    send_sample(CODE_MIN, CODE_MIN, 1'b0);
    set_mode(MODE_FM);
    send_sample(-16'sd16384, 16'sd5, 1'b0);
  endtask

  // long receiver hold-off with the sender pushing back to back, then a full drain
  task automatic test_backpressure();
    int k;
    sink_hold_request = LONG_HOLD;
    for (k = 0; k < 10; k++) send_sample(random_component(), random_component(), 1'b1);
    wait_for_results();
    set_mode(MODE_AM);
    sink_hold_request = LONG_HOLD / 2;
    for (k = 0; k < 6; k++) send_sample(random_component(), random_component(), 1'b1);
    wait_for_results();
  endtask

  // random phases over all modes; mostly rotating phasors with noise mixed in
  task automatic test_random_traffic();
    int phase, k, count, pick;
    logic [MOD_W-1:0] m;
    real amp, angle, step;
    bit phasor_style;
    for (phase = 0; phase < 10; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) m = MODE_FM;
      else if (pick < 8) m = MODE_AM;
      else if (pick == 8) m = MODE_OFF_2;
      else m = MODE_OFF_3;
      set_mode(m);
      count = $urandom_range(60, 100);
      amp   = $urandom_range(500, 32767);
      angle = 0.0;
      step  = ($urandom_range(0, 2000) - 1000.0) / 1000.0 * PI_R;
      phasor_style = ($urandom_range(0, 3) != 0);
      for (k = 0; k < count; k++) begin
        if (!phasor_style || $urandom_range(0, 19) == 0) begin
          send_sample(random_component(), random_component(), 1'b0);
        end else begin
          angle = angle + step + ($urandom_range(0, 200) - 100.0) / 2000.0;
          if ($urandom_range(0, 15) == 0) amp = $urandom_range(200, 33000);
          send_sample(to_code(amp * $cos(angle)), to_code(amp * $sin(angle)), 1'b0);
        end
      end
    end
  endtask

  // result side: random stalls, hold-off requests from the tests, idle-free stretches
  initial begin : result_sink
    int gap_left, free_left, r;
    gap_left  = 0;
    free_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_request > 0) begin
        gap_left  = sink_hold_request;
        free_left = 0;
        sink_hold_request = 0;
      end else if (gap_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 2) free_left = $urandom_range(60, 200);
        else if (r < 12) gap_left = $urandom_range(1, 3);
        else if (r < 15) gap_left = $urandom_range(10, 40);
      end
      if (gap_left > 0) begin
        m_tready <= 1'b0;
        gap_left--;
      end else begin
        m_tready <= 1'b1;
        if (free_left > 0) free_left--;
      end
    end
  end

  // compare each output transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    logic [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_demod.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %0d",
                 $time, $signed(m_tdata));
      end else begin
        want = expected_demod.pop_front();
        if (m_tdata !== want) begin
          error_count++;
          $display("%0t: demod_value expected %0d, actual %0d",
                   $time, $signed(want), $signed(m_tdata));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= TIMEOUT_CYCLES) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, stall_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_fm_directed();
    test_am_directed();
    test_unused_modes();
    test_backpressure();
    test_random_traffic();
    wait_for_results();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/fmam_pkg.sv
src/fmam_datapath.sv
src/fmam_ctrl.sv
src/fm_am_iq_demodulator.sv
dv/tb_fm_am_iq_demodulator.sv
